### rtl/dmm_pkg.sv
package dmm_pkg;

  localparam int DIM_W  = 4;
  localparam int IDX_W  = 3;
  localparam int ACT_W  = 2;
  localparam int VAL_W  = 32;
  localparam int PROD_W = 64;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2
  } reg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols_b;
  } dims_t;

endpackage

### rtl/dmm_ram.sv
module dmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/dmm_front.sv
module dmm_front #(
  parameter int MAX_DIM = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [dmm_pkg::ACT_W-1:0]    in_action,
  input  logic [dmm_pkg::IDX_W-1:0]    in_row,
  input  logic [dmm_pkg::IDX_W-1:0]    in_col,
  input  logic signed [dmm_pkg::VAL_W-1:0] in_value,
  output logic                         cmd_valid,
  output dmm_pkg::cmd_t                cmd,
  input  logic                         cmd_pop
);

  import dmm_pkg::*;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  cmd_t             cq_r [CQ_DEPTH];
  logic [CQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;

  cmd_t cmd_in;
  logic keep;
  logic in_range;
  logic cq_wr;
  logic cq_rd;

  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

  // Classify: drop out-of-range loads and unused action codes here
  always_comb begin
    cmd_in.kind  = CMD_COMPUTE;
    cmd_in.row   = in_row;
    cmd_in.col   = in_col;
    cmd_in.value = in_value;
    keep         = 1'b0;
    case (action_t'(in_action))
      ACT_LOAD_A: begin
        cmd_in.kind = CMD_LOAD_A;
        keep        = in_range;
      end
      ACT_LOAD_B: begin
        cmd_in.kind = CMD_LOAD_B;
        keep        = in_range;
      end
      ACT_COMPUTE: begin
        cmd_in.kind = CMD_COMPUTE;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = cq_r[rd_ptr_r];
  assign cq_wr     = push && !full && keep;
  assign cq_rd     = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = cq_wr ? wr_ptr_r + CQ_PW'(1) : wr_ptr_r;
    rd_ptr_nxt = cq_rd ? rd_ptr_r + CQ_PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CQ_CW'(cq_wr) - CQ_CW'(cq_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cq_wr) begin
      cq_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### rtl/dmm_back.sv
module dmm_back #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dmm_pkg::dims_t                    dims,
  input  logic                              cmd_valid,
  input  dmm_pkg::cmd_t                     cmd,
  output logic                              cmd_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic [dmm_pkg::IDX_W-1:0]         out_row,
  output logic [dmm_pkg::IDX_W-1:0]         out_col,
  output logic signed [dmm_pkg::PROD_W-1:0] out_product_value,
  output logic                              out_last
);

  import dmm_pkg::*;

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(DEPTH);
  localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int OUT_DEPTH = 4;
  localparam int OQ_PW     = $clog2(OUT_DEPTH);
  localparam int OQ_CW     = $clog2(OUT_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [PROD_W-1:0] value;
    logic              last;
  } res_t;

  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = v;
    end
    return d;
  endfunction

  // Sequencer
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [OQ_CW-1:0] credit_r, credit_nxt;

  logic [DIM_W-1:0] nr, nk, nc;
  logic             last_k, last_c, last_r;
  logic             issue, start_elem;

  // Store ports
  logic             a_we, b_we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    a_raddr, b_raddr;
  logic [VAL_W-1:0] a_rdata, b_rdata;

  // MAC pipeline
  logic                     s1_vld_r, s1_first_r, s1_lastk_r, s1_lastrun_r;
  logic [IDX_W-1:0]         s1_row_r, s1_col_r;
  logic                     s2_vld_r, s2_first_r, s2_lastk_r, s2_lastrun_r;
  logic [IDX_W-1:0]         s2_row_r, s2_col_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s3_vld_r, s3_lastrun_r;
  logic [IDX_W-1:0]         s3_row_r, s3_col_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [PROD_W-1:0]        sat_value;
  logic                     fits;

  // Result queue
  res_t             oq_r [OUT_DEPTH];
  logic [OQ_PW-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_CW-1:0] oq_cnt_r;
  logic             oq_push, oq_pop;
  res_t             oq_in, oq_head;

  assign nr = dim_of(dims.rows_a);
  assign nk = dim_of(dims.inner);
  assign nc = dim_of(dims.cols_b);

  assign last_k = ({1'b0, k_r} == nk - DIM_W'(1));
  assign last_c = ({1'b0, c_r} == nc - DIM_W'(1));
  assign last_r = ({1'b0, r_r} == nr - DIM_W'(1));

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;

  // A new element needs a free slot in the result queue; later terms ride along
  assign issue      = (state_r == ST_RUN) && ((k_r != '0) || (credit_r != OQ_CW'(OUT_DEPTH)));
  assign start_elem = issue && (k_r == '0);

  assign waddr   = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
  assign a_we    = cmd_pop && (cmd.kind == CMD_LOAD_A);
  assign b_we    = cmd_pop && (cmd.kind == CMD_LOAD_B);
  assign a_raddr = AW'(int'(r_r) * MAX_DIM + int'(k_r));
  assign b_raddr = AW'(int'(k_r) * MAX_DIM + int'(c_r));

  dmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop && (cmd.kind == CMD_COMPUTE)) begin
          state_nxt = ST_RUN;
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (last_k) begin
            k_nxt = '0;
            if (last_c) begin
              c_nxt = '0;
              if (last_r) begin
                r_nxt     = '0;
                state_nxt = ST_IDLE;
              end else begin
                r_nxt = r_r + IDX_W'(1);
              end
            end else begin
              c_nxt = c_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    credit_nxt = credit_r + OQ_CW'(start_elem) - OQ_CW'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      r_r      <= '0;
      c_r      <= '0;
      k_r      <= '0;
      credit_r <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      r_r      <= r_nxt;
      c_r      <= c_nxt;
      k_r      <= k_nxt;
      credit_r <= credit_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && s2_lastk_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r   <= (k_r == '0);
    s1_lastk_r   <= last_k;
    s1_lastrun_r <= last_k && last_c && last_r;
    s1_row_r     <= r_r;
    s1_col_r     <= c_r;

    prod_r       <= $signed(a_rdata) * $signed(b_rdata);
    s2_first_r   <= s1_first_r;
    s2_lastk_r   <= s1_lastk_r;
    s2_lastrun_r <= s1_lastrun_r;
    s2_row_r     <= s1_row_r;
    s2_col_r     <= s1_col_r;

    if (s2_vld_r) begin
      acc_r <= s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    s3_lastrun_r <= s2_lastrun_r;
    s3_row_r     <= s2_row_r;
    s3_col_r     <= s2_col_r;
  end

  // Clamp to signed 64 bits when the guard bits disagree with the sign
  assign fits = (&acc_r[ACC_W-1:PROD_W-1]) || !(|acc_r[ACC_W-1:PROD_W-1]);
  assign sat_value = fits ? acc_r[PROD_W-1:0] :
                     (acc_r[ACC_W-1] ? {1'b1, {(PROD_W-1){1'b0}}} :
                                       {1'b0, {(PROD_W-1){1'b1}}});

  assign oq_push     = s3_vld_r;
  assign oq_in.row   = s3_row_r;
  assign oq_in.col   = s3_col_r;
  assign oq_in.value = sat_value;
  assign oq_in.last  = s3_lastrun_r;

  assign empty  = (oq_cnt_r == '0);
  assign oq_pop = pop && !empty;

  assign oq_head           = oq_r[oq_rd_r];
  assign out_row           = oq_head.row;
  assign out_col           = oq_head.col;
  assign out_product_value = oq_head.value;
  assign out_last          = oq_head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + OQ_PW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_PW'(1);
      end
      oq_cnt_r <= oq_cnt_r + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= oq_in;
    end
  end

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r != OQ_CW'(OUT_DEPTH)))
    else $error("result queue written while full");

  a_credit_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r >= oq_cnt_r)
    else $error("credit count below result queue occupancy");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= OQ_CW'(OUT_DEPTH))
    else $error("credit count above result queue depth");

  a_emit_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> $past(s2_vld_r && s2_lastk_r))
    else $error("result emitted without a final accumulate");

endmodule

### rtl/dense_matrix_multiply_core.sv
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+--------------------------
// input    | in_action, in_row, in_col, in_value          | push / full
// result   | out_row, out_col, out_product_value, out_last| empty / pop
// config   | psel, penable, pwrite, paddr, pwdata, prdata | pready (tied high)
//
// The front end takes one word per cycle while its two-entry command queue has room.
// Back end: loads are written to the A and B stores as they are dequeued; a compute word
// starts rows_a*cols_b elements of inner terms each, issued at one multiply-accumulate per cycle
// unless a new element waits for a queue slot; results pass s1, s2 and s3 into the result queue.
// Reset (rst_n low, synchronous) empties both queues and sets each dimension to 8.
// A four-word result queue lets the MAC run ahead; hold a new element while four are reserved.
module dense_matrix_multiply_core #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              push,
  output logic                              full,
  input  logic [dmm_pkg::ACT_W-1:0]         in_action,
  input  logic [dmm_pkg::IDX_W-1:0]         in_row,
  input  logic [dmm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [dmm_pkg::VAL_W-1:0]  in_value,

  output logic                              empty,
  input  logic                              pop,
  output logic [dmm_pkg::IDX_W-1:0]         out_row,
  output logic [dmm_pkg::IDX_W-1:0]         out_col,
  output logic signed [dmm_pkg::PROD_W-1:0] out_product_value,
  output logic                              out_last,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dmm_pkg::CFG_AW-1:0]        paddr,
  input  logic [dmm_pkg::CFG_DW-1:0]        pwdata,
  output logic [dmm_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);

  import dmm_pkg::*;

  logic [DIM_W-1:0] rows_a_r, inner_r, cols_b_r;
  logic             cfg_we;
  reg_idx_t         cfg_idx;
  dims_t            dims;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_RESET;
      inner_r  <= DIM_RESET;
      cols_b_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS_A: rows_a_r <= pwdata[DIM_W-1:0];
        REG_INNER:  inner_r  <= pwdata[DIM_W-1:0];
        REG_COLS_B: cols_b_r <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROWS_A: prdata = CFG_DW'(rows_a_r);
      REG_INNER:  prdata = CFG_DW'(inner_r);
      REG_COLS_B: prdata = CFG_DW'(cols_b_r);
      default:    prdata = '0;
    endcase
  end

  assign dims.rows_a = rows_a_r;
  assign dims.inner  = inner_r;
  assign dims.cols_b = cols_b_r;

  dmm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_action (in_action),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  dmm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .dims              (dims),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_last          (out_last)
  );

endmodule
